### hw/rtl/nbb_pkg.sv
// nbb_pkg: types and constants of the nine-bit bus / byte pair bridge
// no dependencies; used by every module of the bridge
package nbb_pkg;

	localparam logic OP_HOST = 1'b0;
	localparam logic OP_BUS  = 1'b1;

	localparam logic DIR_HOST = 1'b0;
	localparam logic DIR_BUS  = 1'b1;

	localparam int unsigned MAX_RES = 3;

	localparam logic [1:0]  WORDS_MAX   = 2'd2;
	localparam logic [1:0]  WORDS_FIRST = 2'd1;

	localparam logic [15:0] CMD_VERSION = 16'hC301;
	localparam logic [15:0] CMD_CB      = 16'hCB00;
	localparam logic [7:0]  CMD_REPLY   = 8'h40;

	localparam logic [15:0] ACK_ASM  = 16'h8000;
	localparam logic [15:0] NAK_ASM  = 16'h9F0F;
	localparam logic [8:0]  ACK_WORD = 9'h000;
	localparam logic [8:0]  NAK_WORD = 9'h1FF;

	typedef struct packed {
		logic       dir;
		logic [7:0] hb;
		logic [8:0] bw;
	} res_t;

	typedef struct packed {
		res_t [MAX_RES-1:0] r;
		logic [1:0]         n;
	} res_set_t;

endpackage

### hw/rtl/nbb_step.sv
// nbb_step: bridge state (assembly word, checksum, word count) and the
// result set of one item; depends on nbb_pkg
module nbb_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic              op,
	input  logic [7:0]        hb,
	input  logic [8:0]        bw,
	output nbb_pkg::res_set_t res
);
	import nbb_pkg::*;

	logic [15:0] asm_q, asm_d;
	logic [7:0]  csum_q, csum_d;
	logic [1:0]  words_q, words_d;
	logic [15:0] w;
	logic [1:0]  words_inc;
	res_t        zero_res;

	assign zero_res = '{dir: DIR_HOST, hb: 8'h00, bw: 9'h000};
	assign w = asm_q | {8'h00, hb};
	assign words_inc = (words_q == WORDS_MAX) ? WORDS_MAX : words_q + 2'd1;

	always_comb begin
		asm_d   = asm_q;
		csum_d  = csum_q;
		words_d = words_q;
		res.r   = {MAX_RES{zero_res}};
		res.n   = 2'd0;
		if (op == OP_HOST) begin
			if (hb[7]) begin
				asm_d = {hb, 8'h00};
			end else begin
				asm_d = w;
				if (w[15:14] == 2'b11) begin
					if (w == CMD_VERSION || w == CMD_CB) begin
						res.r[0] = '{dir: DIR_HOST, hb: w[15:8], bw: 9'h000};
						res.r[1] = '{dir: DIR_HOST, hb: CMD_REPLY, bw: 9'h000};
						res.n    = 2'd2;
					end
				end else begin
					res.r[0] = '{dir: DIR_BUS, hb: 8'h00, bw: {w[12:8], w[3:0]}};
					res.n    = 2'd1;
					csum_d   = 8'h00;
				end
			end
		end else begin
			res.r[0] = '{dir: DIR_HOST, hb: {3'b100, bw[8:4]}, bw: 9'h000};
			res.r[1] = '{dir: DIR_HOST, hb: {4'h0, bw[3:0]}, bw: 9'h000};
			res.n    = 2'd2;
			if (bw[8]) begin
				if (words_inc != WORDS_FIRST) begin
					if (csum_q == bw[7:0]) begin
						asm_d    = ACK_ASM;
						res.r[2] = '{dir: DIR_BUS, hb: 8'h00, bw: ACK_WORD};
					end else begin
						asm_d    = NAK_ASM;
						res.r[2] = '{dir: DIR_BUS, hb: 8'h00, bw: NAK_WORD};
					end
					res.n = 2'd3;
				end
				words_d = 2'd0;
				csum_d  = 8'h00;
			end else begin
				words_d = words_inc;
				csum_d  = csum_q + bw[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asm_q   <= 16'h0000;
			csum_q  <= 8'h00;
			words_q <= 2'd0;
		end else if (fire) begin
			asm_q   <= asm_d;
			csum_q  <= csum_d;
			words_q <= words_d;
		end
	end

endmodule

### hw/rtl/nbb_outq.sv
// nbb_outq: result register that holds up to three results of one item
// and sends them one transfer per cycle while m_tready is high; depends on nbb_pkg
module nbb_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  nbb_pkg::res_set_t res,
	output logic              free,
	input  logic              m_tready,
	output logic              m_tvalid,
	output logic              m_tlast,
	output nbb_pkg::res_t     head
);
	import nbb_pkg::*;

	res_t [MAX_RES-1:0] res_s2;
	logic [1:0]         rem_s2;
	logic               take;

	assign m_tvalid = (rem_s2 != 2'd0);
	assign m_tlast  = (rem_s2 == 2'd1);
	assign take     = m_tvalid && m_tready;
	assign free     = (rem_s2 == 2'd0) || (take && m_tlast);
	assign head     = res_s2[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_s2 <= 2'd0;
		end else if (load && free) begin
			rem_s2 <= res.n;
		end else if (take) begin
			rem_s2 <= rem_s2 - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			res_s2 <= res.r;
		end else if (take) begin
			res_s2[0] <= res_s2[1];
			res_s2[1] <= res_s2[2];
		end
	end

endmodule

### hw/rtl/nine_bit_bus_byte_pair_bridge_core.sv
// nine_bit_bus_byte_pair_bridge_core: top level of the bridge
// depends on nbb_pkg, nbb_step and nbb_outq
//
// Bridges a 9-bit-word bus and a byte link. s_tuser picks the source of an
// item (0 host byte in s_tdata[7:0], 1 bus word in s_tdata[16:8]); results
// leave one transfer per cycle while m_tready is high, m_tuser giving the
// direction and m_tlast marking the final result of an item. An item is
// held in an input register, evaluated combinationally into a result
// register of up to three results, and offered from there. The input takes
// one transfer per cycle as long as the result port drains; an item's
// results hold the result register until the last is taken, so items that
// produce no result (high host bytes, unknown commands) pass at one per
// cycle and a bus word with ack or nak holds the port for its three results.
module nine_bit_bus_byte_pair_bridge_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // host_byte[7:0], bus_word[16:8], zero fill
	input  logic        s_tuser,  // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // host_byte_out[7:0], bus_word_out[16:8], zero fill
	output logic        m_tuser,  // direction
	output logic        m_tlast
);
	import nbb_pkg::*;

	logic       vld_s1;
	logic       op_s1;
	logic [7:0] hb_s1;
	logic [8:0] bw_s1;
	logic       adv;
	logic       free;
	res_set_t   res;
	res_t       head;

	assign adv      = vld_s1 && ((res.n == 2'd0) || free);
	assign s_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1 <= s_tuser;
			hb_s1 <= s_tdata[7:0];
			bw_s1 <= s_tdata[16:8];
		end
	end

	nbb_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.op     (op_s1),
		.hb     (hb_s1),
		.bw     (bw_s1),
		.res    (res)
	);

	nbb_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv),
		.res      (res),
		.free     (free),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tlast  (m_tlast),
		.head     (head)
	);

	assign m_tdata = {7'h00, head.bw, head.hb};
	assign m_tuser = head.dir;

endmodule

### hw/rtl/nbb_checker.sv
// nbb_checker: port-level checks of the bridge, bound to the top level
// depends on nbb_pkg and nine_bit_bus_byte_pair_bridge_core
module nbb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);
	import nbb_pkg::*;

	// stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result transfer changed");

	// results of one item leave without gaps
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside a result run");

	// a bus word is always the final result of its item
	a_bus_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == DIR_BUS |-> m_tlast && m_tdata[7:0] == 8'h00)
		else $error("bus word not final or host byte not zero");

	// host bytes carry no bus word and no fill bits
	a_host_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == DIR_HOST |-> m_tdata[23:8] == 16'h0000)
		else $error("host byte transfer carries stray bits");

endmodule

bind nine_bit_bus_byte_pair_bridge_core nbb_checker u_nbb_checker (.*);

### verif/nine_bit_bus_byte_pair_bridge_core_tb.sv
// testbench for nine_bit_bus_byte_pair_bridge_core: directed and random host bytes and bus words
// a transaction-level predictor checks every output transfer in order; depends on nbb_pkg and the core
module nine_bit_bus_byte_pair_bridge_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import nbb_pkg::*;

	localparam int ITEM_COUNT     = 370;
	localparam int DIRECTED_ITEMS = 24;
	localparam int SECOND_DRAIN   = 200;
	localparam int HOLD_AFTER     = 150;
	localparam int HOLD_CYCLES    = 400;
	localparam int CYCLE_LIMIT    = 200000;

	typedef struct packed {
		logic       op;
		logic [7:0] hb;
		logic [8:0] bw;
		logic       drain;
	} bridge_in_t;

	typedef struct packed {
		logic       dir;
		logic [7:0] hb;
		logic [8:0] bw;
		logic       last;
	} bridge_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = 24'd0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	bridge_in_t  pending[$];
	bridge_out_t item_out[$];
	bridge_out_t expected_out[$];

	logic [15:0] asm_word = 16'd0;
	logic [7:0]  pkt_sum = 8'd0;
	logic [1:0]  pkt_words = 2'd0;

	logic s_fire = 1'b0;
	logic m_fire = 1'b0;
	int   errors = 0;
	int   items_in = 0;
	int   results_out = 0;
	int   acks = 0;
	int   naks = 0;
	int   cmd_replies = 0;
	int   cycles = 0;
	int   tx_count = 0;
	int   gap_left = 0;
	int   rx_count = 0;
	int   stall_left = 0;
	int   hold_left = 0;
	bit   hold_done = 1'b0;

	nine_bit_bus_byte_pair_bridge_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always #4 clk = ~clk;

	function void push_result(logic d, logic [7:0] h, logic [8:0] b);
		bridge_out_t x;
		x.dir = d;
		x.hb = h;
		x.bw = b;
		x.last = 1'b0;
		item_out.push_back(x);
	endfunction

	// high byte loads the top half, low byte completes the word
	function void assemble_byte(logic [7:0] b);
		if (b[7]) begin
			asm_word = {b, 8'h00};
		end else begin
			asm_word = asm_word | {8'h00, b};
			if (asm_word[15:14] == 2'b11) begin
				if (asm_word == CMD_VERSION || asm_word == CMD_CB) begin
					push_result(DIR_HOST, asm_word[15:8], 9'd0);
					push_result(DIR_HOST, CMD_REPLY, 9'd0);
					cmd_replies++;
				end
			end else begin
				push_result(DIR_BUS, 8'd0, {asm_word[12:8], asm_word[3:0]});
				pkt_sum = 8'd0;
			end
		end
	endfunction

	function void bridge_item(logic op, logic [7:0] hb, logic [8:0] bw);
		bridge_out_t x;
		item_out.delete();
		if (op == OP_HOST) begin
			assemble_byte(hb);
		end else begin
			push_result(DIR_HOST, {3'b100, bw[8:4]}, 9'd0);
			push_result(DIR_HOST, {4'd0, bw[3:0]}, 9'd0);
			if (pkt_words != WORDS_MAX)
				pkt_words = pkt_words + 2'd1;
			if (bw[8]) begin
				if (pkt_words != WORDS_FIRST) begin
					if (pkt_sum == bw[7:0]) begin
						assemble_byte(ACK_ASM[15:8]);
						assemble_byte(ACK_ASM[7:0]);
						acks++;
					end else begin
						assemble_byte(NAK_ASM[15:8]);
						assemble_byte(NAK_ASM[7:0]);
						naks++;
					end
				end
				pkt_words = 2'd0;
				pkt_sum = 8'd0;
			end else begin
				pkt_sum = pkt_sum + bw[7:0];
			end
		end
		if (item_out.size() != 0) begin
			x = item_out.pop_back();
			x.last = 1'b1;
			item_out.push_back(x);
		end
		foreach (item_out[i])
			expected_out.push_back(item_out[i]);
	endfunction

	function void queue_item(logic op, logic [7:0] hb, logic [8:0] bw);
		bridge_in_t x;
		x.op = op;
		x.hb = hb;
		x.bw = bw;
		// sender waits for all results before these
		x.drain = (pending.size() == DIRECTED_ITEMS || pending.size() == SECOND_DRAIN);
		pending.push_back(x);
	endfunction

	// driver
	always @(negedge clk) begin
		bridge_in_t cur;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_fire)
				tx_count = tx_count + 1;
			if (!(s_tvalid && !s_fire)) begin
				if (gap_left > 0) begin
					s_tvalid <= 1'b0;
					gap_left = gap_left - 1;
				end else if (pending.size() != 0 &&
						(!pending[0].drain || expected_out.size() == 0)) begin
					cur = pending.pop_front();
					s_tuser <= cur.op;
					s_tdata <= {7'd0, cur.bw, cur.hb};
					s_tvalid <= 1'b1;
					gap_left = ((tx_count / 16) % 4 == 1) ? 0 : $urandom_range(0, 9);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver with one long hold-off
	always @(negedge clk) begin
		int stall;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_fire)
				rx_count = rx_count + 1;
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left = hold_left - 1;
			end else if (!hold_done && rx_count >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else if (m_fire) begin
				stall = ((rx_count / 16) % 4 == 3) ? 0 : $urandom_range(0, 9);
				if (stall > 0) begin
					stall_left = stall - 1;
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
			end else if (stall_left > 0) begin
				stall_left = stall_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// monitor and prediction
	always @(posedge clk) begin
		bridge_out_t want;
		if (m_tvalid && m_tready) begin
			results_out++;
			if (expected_out.size() == 0) begin
				$error("unexpected transfer: direction %0d host_byte_out %0h bus_word_out %0h",
					m_tuser, m_tdata[7:0], m_tdata[16:8]);
				errors++;
			end else begin
				want = expected_out.pop_front();
				if (m_tuser !== want.dir) begin
					$error("direction: expected %0d, got %0d", want.dir, m_tuser);
					errors++;
				end
				if (m_tdata[7:0] !== want.hb) begin
					$error("host_byte_out: expected %0h, got %0h", want.hb, m_tdata[7:0]);
					errors++;
				end
				if (m_tdata[16:8] !== want.bw) begin
					$error("bus_word_out: expected %0h, got %0h", want.bw, m_tdata[16:8]);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, m_tlast);
					errors++;
				end
			end
		end
		if (s_tvalid && s_tready) begin
			items_in++;
			bridge_item(s_tuser, s_tdata[7:0], s_tdata[16:8]);
		end
		s_fire <= s_tvalid && s_tready;
		m_fire <= m_tvalid && m_tready;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("nine_bit_bus_byte_pair_bridge_core_tb failed");
			$finish;
		end
	end

	initial begin
		int         kind;
		int         n;
		logic [7:0] sum;
		logic [7:0] lo;
		logic [7:0] hi;
		logic [8:0] w;

		// low byte straight after reset, then edge values
		queue_item(OP_HOST, 8'h05, 9'd0);
		queue_item(OP_HOST, 8'h7F, 9'd0);
		queue_item(OP_HOST, 8'hFF, 9'd0);
		queue_item(OP_HOST, 8'h00, 9'd0);
		// version and cb commands, then host words bound for the bus
		queue_item(OP_HOST, CMD_VERSION[15:8], 9'd0);
		queue_item(OP_HOST, CMD_VERSION[7:0], 9'd0);
		queue_item(OP_HOST, CMD_CB[15:8], 9'd0);
		queue_item(OP_HOST, CMD_CB[7:0], 9'd0);
		queue_item(OP_HOST, 8'h80, 9'd0);
		queue_item(OP_HOST, 8'h7F, 9'd0);
		queue_item(OP_HOST, 8'h9F, 9'd0);
		queue_item(OP_HOST, 8'h70, 9'd0);
		// mode word first in packet, then ack, nak and saturated count
		queue_item(OP_BUS, 8'd0, 9'h1FF);
		queue_item(OP_BUS, 8'd0, 9'h000);
		queue_item(OP_BUS, 8'd0, 9'h0FF);
		queue_item(OP_BUS, 8'd0, 9'h1FF);
		queue_item(OP_BUS, 8'd0, 9'h012);
		queue_item(OP_BUS, 8'd0, 9'h1AB);
		queue_item(OP_BUS, 8'd0, 9'h0F0);
		queue_item(OP_BUS, 8'd0, 9'h010);
		queue_item(OP_BUS, 8'd0, 9'h0A5);
		queue_item(OP_BUS, 8'd0, 9'h1A5);
		// unknown command
		queue_item(OP_HOST, 8'hC0, 9'd0);
		queue_item(OP_HOST, 8'h01, 9'd0);

		while (pending.size() < ITEM_COUNT) begin
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				n = $urandom_range(0, 4);
				sum = 8'd0;
				for (int k = 0; k < n; k++) begin
					lo = 8'($urandom_range(0, 255));
					sum = sum + lo;
					queue_item(OP_BUS, 8'd0, {1'b0, lo});
					if ($urandom_range(0, 9) == 0) begin
						hi = 8'h80 | 8'($urandom_range(0, 127));
						queue_item(OP_HOST, hi, 9'd0);
						queue_item(OP_HOST, 8'($urandom_range(0, 127)), 9'd0);
					end
				end
				lo = sum;
				if ($urandom_range(0, 3) == 0)
					lo = 8'($urandom_range(0, 255));
				queue_item(OP_BUS, 8'd0, {1'b1, lo});
			end else if (kind < 65) begin
				hi = 8'h80 | 8'($urandom_range(0, 127));
				queue_item(OP_HOST, hi, 9'd0);
				queue_item(OP_HOST, 8'($urandom_range(0, 127)), 9'd0);
			end else if (kind < 75) begin
				n = $urandom_range(0, 2);
				if (n == 0) begin
					queue_item(OP_HOST, CMD_VERSION[15:8], 9'd0);
					queue_item(OP_HOST, CMD_VERSION[7:0], 9'd0);
				end else if (n == 1) begin
					queue_item(OP_HOST, CMD_CB[15:8], 9'd0);
					queue_item(OP_HOST, CMD_CB[7:0], 9'd0);
				end else begin
					hi = 8'hC0 | 8'($urandom_range(0, 63));
					queue_item(OP_HOST, hi, 9'd0);
					queue_item(OP_HOST, 8'($urandom_range(0, 127)), 9'd0);
				end
			end else begin
				lo = 8'($urandom_range(0, 255));
				w = 9'($urandom_range(0, 511));
				queue_item(1'($urandom_range(0, 1)), lo, w);
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_out.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d items in, %0d results out: %0d acks, %0d naks, %0d command replies",
			items_in, results_out, acks, naks, cmd_replies);
		$display("receiver hold-off of %0d cycles, sender drained twice", HOLD_CYCLES);
		if (errors == 0 && expected_out.size() == 0) begin
			$display("nine_bit_bus_byte_pair_bridge_core_tb passed");
		end else begin
			$display("nine_bit_bus_byte_pair_bridge_core_tb failed");
		end
		$finish;
	end

endmodule
